// File: sv/sorted_key_value_table_core_assert.svh
// Assertion macros for the sorted key and record-id table.
`ifndef SORTED_KEY_VALUE_TABLE_CORE_ASSERT_SVH
`define SORTED_KEY_VALUE_TABLE_CORE_ASSERT_SVH

`ifndef SYNTHESIS

`define SKVT_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("skvt assertion failed");

`define SKVT_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("skvt assertion failed");

`define SKVT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("skvt assertion failed");

`else

`define SKVT_ASSERT_ALWAYS(label, clk, rst, cond)
`define SKVT_ASSERT_SAME(label, clk, rst, ante, cons)
`define SKVT_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: sv/skvt_pkg.sv
`default_nettype none

package skvt_pkg;

   localparam int MAX_ENTRIES = 32;
   localparam int COUNT_W     = $clog2(MAX_ENTRIES + 1);
   localparam int KEY_W       = 32;
   localparam int REC_W       = 64;
   localparam int ENTRY_CNT_W = 6;
   localparam int STATUS_W    = 2;

   typedef enum logic [0:0] {
      CMD_LOOKUP = 1'b0,
      CMD_INSERT = 1'b1
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_LOOKUP   = 2'd0,
      STATUS_INSERTED = 2'd1,
      STATUS_UPDATED  = 2'd2,
      STATUS_REJECTED = 2'd3
   } status_type;

   typedef enum logic [0:0] {
      ST_IDLE  = 1'b0,
      ST_APPLY = 1'b1
   } state_type;

   typedef struct packed {
      logic less;
      logic eq;
   } cell_flags_type;

   typedef struct packed {
      logic insert;
      logic update;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// File: sv/skvt_cell.sv
`default_nettype none

module skvt_cell (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              cmp_en,
   input  wire logic                              valid,
   input  wire logic signed [skvt_pkg::KEY_W-1:0] cmp_key,
   input  wire skvt_pkg::cell_ctrl_type           ctrl,
   input  wire logic signed [skvt_pkg::KEY_W-1:0] new_key,
   input  wire logic        [skvt_pkg::REC_W-1:0] new_rec,
   input  wire logic                              prev_less,
   input  wire logic signed [skvt_pkg::KEY_W-1:0] prev_key,
   input  wire logic        [skvt_pkg::REC_W-1:0] prev_rec,
   output      logic signed [skvt_pkg::KEY_W-1:0] key,
   output      logic        [skvt_pkg::REC_W-1:0] rec,
   output      skvt_pkg::cell_flags_type          flags
);

   logic signed [skvt_pkg::KEY_W-1:0] key_ff, key_in;
   logic        [skvt_pkg::REC_W-1:0] rec_ff, rec_in;
   skvt_pkg::cell_flags_type          flags_ff, flags_in;

   always_comb begin
      flags_in = flags_ff;
      if (cmp_en) begin
         flags_in.less = valid && (key_ff < cmp_key);
         flags_in.eq   = valid && (key_ff == cmp_key);
      end
   end

   always_comb begin
      key_in = key_ff;
      rec_in = rec_ff;
      if (ctrl.insert && !flags_ff.less) begin
         if (prev_less) begin
            key_in = new_key;
            rec_in = new_rec;
         end else begin
            key_in = prev_key;
            rec_in = prev_rec;
         end
      end else if (ctrl.update && flags_ff.eq) begin
         rec_in = new_rec;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      rec_ff <= rec_in;
      if (reset) begin
         flags_ff <= '0;
      end else begin
         flags_ff <= flags_in;
      end
   end

   assign key   = key_ff;
   assign rec   = rec_ff;
   assign flags = flags_ff;

endmodule

`default_nettype wire

// File: sv/sorted_key_value_table_core.sv
`default_nettype none

`include "sorted_key_value_table_core_assert.svh"

// Sorted table of signed 32-bit keys with 64-bit record ids, held in a row of
// cells in ascending key order. A lookup (req_cmd 0) reports whether the key is
// stored and its record id; an insert (req_cmd 1) updates the record id of a
// stored key, or places the pair at its sorted place while every larger entry
// moves up one cell; an insert into a full table is rejected with status 3 and
// changes nothing. A transaction is taken when start is high and busy is low.
// In each transaction, every cell compares its key with req_key in the cycle
// start is taken, and all cells shift or update together in the next cycle;
// busy is high for that one cycle. The result appears on the rsp_ ports
// for exactly one cycle, marked by rsp_valid, in the cycle after that; the
// receiver cannot stall it and must capture it then. A new transaction may be
// started in that same cycle; while busy is high, start is not taken.
// After reset the table is empty; no clearing pass is needed.
module sorted_key_value_table_core (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    start,
   output      logic                                    busy,
   input  wire logic                                    req_cmd,
   input  wire logic signed [skvt_pkg::KEY_W-1:0]       req_key,
   input  wire logic        [skvt_pkg::REC_W-1:0]       req_record_id,
   output      logic                                    rsp_valid,
   output      logic                                    rsp_found,
   output      logic        [skvt_pkg::REC_W-1:0]       rsp_found_record,
   output      logic        [skvt_pkg::STATUS_W-1:0]    rsp_status,
   output      logic        [skvt_pkg::ENTRY_CNT_W-1:0] rsp_entry_count
);

   localparam int N = skvt_pkg::MAX_ENTRIES;

   skvt_pkg::state_type                      state_ff, state_in;
   skvt_pkg::cmd_type                        cmd_ff;
   logic signed [skvt_pkg::KEY_W-1:0]        key_ff;
   logic        [skvt_pkg::REC_W-1:0]        rec_ff;
   logic        [skvt_pkg::COUNT_W-1:0]      count_ff, count_in;
   logic                                     rsp_valid_ff, rsp_valid_in;
   logic                                     rsp_found_ff, rsp_found_in;
   logic        [skvt_pkg::REC_W-1:0]        rsp_record_ff, rsp_record_in;
   skvt_pkg::status_type                     rsp_status_ff, rsp_status_in;

   logic                                     accept;
   logic                                     full;
   logic                                     hit;
   logic        [skvt_pkg::REC_W-1:0]        match_rec;
   skvt_pkg::cell_ctrl_type                  ctrl;

   logic signed [skvt_pkg::KEY_W-1:0]        cell_key [N];
   logic        [skvt_pkg::REC_W-1:0]        cell_rec [N];
   skvt_pkg::cell_flags_type                 cell_flags [N];
   logic        [N-1:0]                      less_vec;
   logic        [N-1:0]                      eq_vec;

   assign busy   = (state_ff == skvt_pkg::ST_APPLY);
   assign accept = start && !busy;

   genvar gi;
   generate
      for (gi = 0; gi < N; gi++) begin : g_cell
         logic                              valid;
         logic                              prev_less;
         logic signed [skvt_pkg::KEY_W-1:0] prev_key;
         logic        [skvt_pkg::REC_W-1:0] prev_rec;

         assign valid = (count_ff > skvt_pkg::COUNT_W'(gi));

         if (gi == 0) begin : g_head
            assign prev_less = 1'b1;
            assign prev_key  = '0;
            assign prev_rec  = '0;
         end else begin : g_body
            assign prev_less = less_vec[gi-1];
            assign prev_key  = cell_key[gi-1];
            assign prev_rec  = cell_rec[gi-1];
         end

         skvt_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .cmp_en    (accept),
            .valid     (valid),
            .cmp_key   (req_key),
            .ctrl      (ctrl),
            .new_key   (key_ff),
            .new_rec   (rec_ff),
            .prev_less (prev_less),
            .prev_key  (prev_key),
            .prev_rec  (prev_rec),
            .key       (cell_key[gi]),
            .rec       (cell_rec[gi]),
            .flags     (cell_flags[gi])
         );

         assign less_vec[gi] = cell_flags[gi].less;
         assign eq_vec[gi]   = cell_flags[gi].eq;
      end
   endgenerate

   always_comb begin
      match_rec = '0;
      for (int i = 0; i < N; i++) begin
         match_rec = match_rec | (eq_vec[i] ? cell_rec[i] : '0);
      end
   end

   assign full = (count_ff == skvt_pkg::COUNT_W'(N));
   assign hit  = |eq_vec;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      ctrl          = '0;
      rsp_valid_in  = 1'b0;
      rsp_found_in  = 1'b0;
      rsp_record_in = '0;
      rsp_status_in = skvt_pkg::STATUS_LOOKUP;
      case (state_ff)
         skvt_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = skvt_pkg::ST_APPLY;
            end
         end
         skvt_pkg::ST_APPLY: begin
            state_in     = skvt_pkg::ST_IDLE;
            rsp_valid_in = 1'b1;
            if (cmd_ff == skvt_pkg::CMD_LOOKUP) begin
               rsp_found_in  = hit;
               rsp_record_in = match_rec;
               rsp_status_in = skvt_pkg::STATUS_LOOKUP;
            end else if (full) begin
               rsp_status_in = skvt_pkg::STATUS_REJECTED;
            end else if (hit) begin
               ctrl.update   = 1'b1;
               rsp_found_in  = 1'b1;
               rsp_status_in = skvt_pkg::STATUS_UPDATED;
            end else begin
               ctrl.insert   = 1'b1;
               count_in      = count_ff + skvt_pkg::COUNT_W'(1);
               rsp_status_in = skvt_pkg::STATUS_INSERTED;
            end
         end
         default: begin
            state_in = skvt_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= skvt_pkg::cmd_type'(req_cmd);
         key_ff <= req_key;
         rec_ff <= req_record_id;
      end
      rsp_found_ff  <= rsp_found_in;
      rsp_record_ff <= rsp_record_in;
      rsp_status_ff <= rsp_status_in;
      if (reset) begin
         state_ff     <= skvt_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_found_record = rsp_record_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_entry_count  = skvt_pkg::ENTRY_CNT_W'(count_ff);

   `SKVT_ASSERT_NEXT(a_apply_responds, clock, reset, busy, rsp_valid)
   `SKVT_ASSERT_ALWAYS(a_count_bounded, clock, reset, count_ff <= skvt_pkg::COUNT_W'(N))
   `SKVT_ASSERT_SAME(a_single_match, clock, reset, busy, $onehot0(eq_vec))
   `SKVT_ASSERT_SAME(a_reject_only_full, clock, reset,
      rsp_valid && rsp_status == skvt_pkg::STATUS_REJECTED, full)

endmodule

`default_nettype wire
